// ===== rtl/bmpdec_pkg.sv =====
`default_nettype none
package bmpdec_pkg;

	typedef enum logic [2:0] {
		ST_PIXEL     = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_TOO_SHORT = 3'd2,
		ST_BAD_MARK  = 3'd3,
		ST_UNSUP     = 3'd4,
		ST_TRUNC     = 3'd5
	} status_t;

	localparam logic [15:0] MIN_LEN      = 16'd54;
	localparam logic [7:0]  CHAR_B       = 8'h42;
	localparam logic [7:0]  CHAR_M       = 8'h4D;
	localparam logic [7:0]  DEPTH24      = 8'd24;
	localparam logic [7:0]  DEPTH32      = 8'd32;
	localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

	// One result item as it leaves the block.
	typedef struct packed {
		status_t     status;
		logic        last;
		logic [15:0] x_coord;
		logic [14:0] y_coord;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [15:0] image_width;
		logic [14:0] image_height;
	} res_t;

	// Commands from the controller to the datapath, valid for the accepted byte only.
	typedef struct packed {
		logic    emit;
		status_t status;
		logic    last;
		logic    hdr_clear;
		logic    ld_off_lo;
		logic    ld_off_hi;
		logic    ld_w_lo;
		logic    ld_w_hi;
		logic    ld_h_lo;
		logic    ld_h_hi;
		logic    ld_depth;
		logic    pix_clear;
		logic    pix_byte;
	} cmd_t;

	// Status flags from the datapath to the controller.
	typedef struct packed {
		logic        short_file;
		logic        byte_is_b;
		logic        byte_is_m;
		logic        hdr_unsup;
		logic        hdr_trunc;
		logic        hdr_empty;
		logic        off_is_min;
		logic [15:0] pixel_start;
		logic        chan_done;
		logic        row_end;
		logic        last_pixel;
		logic [1:0]  pad_amt;
	} stat_t;

endpackage
`default_nettype wire

// ===== rtl/bmpdec_ctrl.sv =====
`default_nettype none
module bmpdec_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                acc,
	input  wire logic                eof,
	input  wire bmpdec_pkg::stat_t   stat,
	output bmpdec_pkg::cmd_t         cmd
);

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_GAP    = 3'd1,
		PH_PIXELS = 3'd2,
		PH_PAD    = 3'd3,
		PH_DRAIN  = 3'd4
	} phase_t;

	localparam logic [15:0] POS_MARK_B = 16'd0;
	localparam logic [15:0] POS_MARK_M = 16'd1;
	localparam logic [15:0] POS_OFF_LO = 16'd10;
	localparam logic [15:0] POS_OFF_HI = 16'd11;
	localparam logic [15:0] POS_W_LO   = 16'd18;
	localparam logic [15:0] POS_W_HI   = 16'd19;
	localparam logic [15:0] POS_H_LO   = 16'd22;
	localparam logic [15:0] POS_H_HI   = 16'd23;
	localparam logic [15:0] POS_DEPTH  = 16'd28;
	localparam logic [15:0] POS_LAST   = bmpdec_pkg::MIN_LEN - 16'd1;

	phase_t              phase_q, phase_n;
	logic [15:0]         pos_q, pos_n;
	logic [1:0]          pad_q, pad_n;
	logic                err;
	bmpdec_pkg::status_t err_code;
	logic                finished;

	always_comb begin
		cmd      = '0;
		phase_n  = phase_q;
		pos_n    = pos_q;
		pad_n    = pad_q;
		err      = 1'b0;
		err_code = bmpdec_pkg::ST_PIXEL;
		finished = 1'b0;
		if (acc) begin
			case (phase_q)
				PH_HEADER: begin
					pos_n = pos_q + 16'd1;
					case (pos_q)
						POS_MARK_B: begin
							cmd.hdr_clear = 1'b1;
							if (stat.short_file) begin
								err      = 1'b1;
								err_code = bmpdec_pkg::ST_TOO_SHORT;
							end else if (!stat.byte_is_b) begin
								err      = 1'b1;
								err_code = bmpdec_pkg::ST_BAD_MARK;
							end
						end
						POS_MARK_M: begin
							if (!stat.byte_is_m) begin
								err      = 1'b1;
								err_code = bmpdec_pkg::ST_BAD_MARK;
							end
						end
						POS_OFF_LO: cmd.ld_off_lo = 1'b1;
						POS_OFF_HI: cmd.ld_off_hi = 1'b1;
						POS_W_LO:   cmd.ld_w_lo = 1'b1;
						POS_W_HI:   cmd.ld_w_hi = 1'b1;
						POS_H_LO:   cmd.ld_h_lo = 1'b1;
						POS_H_HI:   cmd.ld_h_hi = 1'b1;
						POS_DEPTH: begin
							cmd.ld_depth = 1'b1;
							if (stat.hdr_unsup) begin
								err      = 1'b1;
								err_code = bmpdec_pkg::ST_UNSUP;
							end else if (stat.hdr_trunc) begin
								err      = 1'b1;
								err_code = bmpdec_pkg::ST_TRUNC;
							end else if (stat.hdr_empty) begin
								err      = 1'b1;
								err_code = bmpdec_pkg::ST_EMPTY;
							end
						end
						POS_LAST: begin
							cmd.pix_clear = 1'b1;
							phase_n = stat.off_is_min ? PH_PIXELS : PH_GAP;
						end
						default: ;
					endcase
					if (err) begin
						cmd.emit   = 1'b1;
						cmd.status = err_code;
						cmd.last   = 1'b1;
						finished   = 1'b1;
						phase_n    = PH_DRAIN;
					end
				end
				PH_GAP: begin
					pos_n = pos_q + 16'd1;
					if ({1'b0, pos_q} + 17'd1 >= {1'b0, stat.pixel_start}) begin
						phase_n = PH_PIXELS;
					end
				end
				PH_PIXELS: begin
					cmd.pix_byte = 1'b1;
					if (stat.chan_done) begin
						cmd.emit   = 1'b1;
						cmd.status = bmpdec_pkg::ST_PIXEL;
						cmd.last   = stat.last_pixel;
						if (stat.last_pixel) begin
							finished = 1'b1;
							phase_n  = PH_DRAIN;
						end else if (stat.row_end && stat.pad_amt != 2'd0) begin
							pad_n   = stat.pad_amt;
							phase_n = PH_PAD;
						end
					end
				end
				PH_PAD: begin
					if (pad_q != 2'd0) begin
						pad_n = pad_q - 2'd1;
					end
					if (pad_q <= 2'd1) begin
						phase_n = PH_PIXELS;
					end
				end
				PH_DRAIN: ;
				default: phase_n = PH_HEADER;
			endcase
			// A file that ends early reports truncation in place of whatever this byte gave.
			if (eof) begin
				if (!finished && phase_q != PH_DRAIN) begin
					cmd.emit   = 1'b1;
					cmd.status = bmpdec_pkg::ST_TRUNC;
					cmd.last   = 1'b1;
				end
				cmd.pix_clear = 1'b1;
				phase_n       = PH_HEADER;
				pos_n         = 16'd0;
				pad_n         = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= 16'd0;
			pad_q   <= 2'd0;
		end else begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			pad_q   <= pad_n;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bmpdec_dp.sv =====
`default_nettype none
module bmpdec_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [31:0]        cfg_data,
	input  wire logic [7:0]         data_byte,
	input  wire bmpdec_pkg::cmd_t   cmd,
	output bmpdec_pkg::stat_t       stat,
	output bmpdec_pkg::res_t        res
);

	logic [31:0] file_length_q;
	logic [15:0] off_q, off_n;
	logic [15:0] w_q, w_n;
	logic [15:0] h_q, h_n;
	logic        four_q, four_n;
	logic [15:0] col_q, col_n;
	logic [14:0] row_q, row_n;
	logic [1:0]  ci_q, ci_n;
	logic [23:0] partial_q, partial_n;
	logic [23:0] pix_word;
	logic        depth_ok;

	// Size check pipeline: runs freely, settles well before the depth byte arrives.
	logic [17:0] scan3;
	logic [32:0] prod3_s1, prod4_s1;
	logic [33:0] need3_s2, need4_s2;
	logic [33:0] need_sel;

	assign scan3 = ({2'b00, w_q} * 18'd3 + 18'd3) & ~18'd3;

	always_ff @(posedge clk) begin
		prod3_s1 <= 33'(scan3) * 33'(h_q[14:0]);
		prod4_s1 <= 33'({w_q, 2'b00}) * 33'(h_q[14:0]);
		need3_s2 <= 34'(prod3_s1) + 34'(off_q);
		need4_s2 <= 34'(prod4_s1) + 34'(off_q);
	end

	always_comb begin
		off_n  = off_q;
		w_n    = w_q;
		h_n    = h_q;
		four_n = four_q;
		if (cmd.hdr_clear) begin
			off_n  = 16'd0;
			w_n    = 16'd0;
			h_n    = 16'd0;
			four_n = 1'b0;
		end
		if (cmd.ld_off_lo) off_n[7:0] = data_byte;
		if (cmd.ld_off_hi) off_n[15:8] = data_byte;
		if (cmd.ld_w_lo) w_n[7:0] = data_byte;
		if (cmd.ld_w_hi) w_n[15:8] = data_byte;
		if (cmd.ld_h_lo) h_n[7:0] = data_byte;
		if (cmd.ld_h_hi) h_n[15:8] = data_byte;
		if (cmd.ld_depth) four_n = (data_byte == bmpdec_pkg::DEPTH32);
	end

	always_comb begin
		pix_word = partial_q;
		case (ci_q)
			2'd0: pix_word[7:0] = data_byte;
			2'd1: pix_word[15:8] = data_byte;
			2'd2: pix_word[23:16] = data_byte;
			default: ;
		endcase
	end

	always_comb begin
		col_n     = col_q;
		row_n     = row_q;
		ci_n      = ci_q;
		partial_n = partial_q;
		if (cmd.pix_byte) begin
			if (stat.chan_done) begin
				col_n     = col_q + 16'd1;
				ci_n      = 2'd0;
				partial_n = 24'd0;
				if (!stat.last_pixel && stat.row_end) begin
					col_n = 16'd0;
					row_n = row_q + 15'd1;
				end
			end else begin
				ci_n      = ci_q + 2'd1;
				partial_n = pix_word;
			end
		end
		if (cmd.pix_clear) begin
			col_n     = 16'd0;
			row_n     = 15'd0;
			ci_n      = 2'd0;
			partial_n = 24'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= 32'd0;
			off_q         <= 16'd0;
			w_q           <= 16'd0;
			h_q           <= 16'd0;
			four_q        <= 1'b0;
			col_q         <= 16'd0;
			row_q         <= 15'd0;
			ci_q          <= 2'd0;
			partial_q     <= 24'd0;
		end else begin
			if (cfg_we) begin
				file_length_q <= cfg_data;
			end
			off_q     <= off_n;
			w_q       <= w_n;
			h_q       <= h_n;
			four_q    <= four_n;
			col_q     <= col_n;
			row_q     <= row_n;
			ci_q      <= ci_n;
			partial_q <= partial_n;
		end
	end

	assign depth_ok = (data_byte == bmpdec_pkg::DEPTH24) || (data_byte == bmpdec_pkg::DEPTH32);
	assign need_sel = (data_byte == bmpdec_pkg::DEPTH32) ? need4_s2 : need3_s2;

	always_comb begin
		stat.short_file  = file_length_q < {16'd0, bmpdec_pkg::MIN_LEN};
		stat.byte_is_b   = data_byte == bmpdec_pkg::CHAR_B;
		stat.byte_is_m   = data_byte == bmpdec_pkg::CHAR_M;
		stat.hdr_unsup   = !depth_ok || h_q[15] || (off_q < bmpdec_pkg::MIN_LEN);
		stat.hdr_trunc   = need_sel > {2'b00, file_length_q};
		stat.hdr_empty   = (w_q == 16'd0) || (h_q == 16'd0);
		stat.off_is_min  = off_q == bmpdec_pkg::MIN_LEN;
		stat.pixel_start = off_q;
		stat.chan_done   = four_q ? (ci_q == 2'd3) : (ci_q >= 2'd2);
		stat.row_end     = {1'b0, col_q} + 17'd1 >= {1'b0, w_q};
		stat.last_pixel  = stat.row_end && ({1'b0, row_q} + 16'd1 >= h_q);
		stat.pad_amt     = four_q ? 2'd0 : w_q[1:0];
	end

	always_comb begin
		res.status       = cmd.status;
		res.last         = cmd.last;
		res.image_width  = w_n;
		res.image_height = h_n[14:0];
		if (cmd.status == bmpdec_pkg::ST_PIXEL) begin
			res.x_coord = col_q;
			res.y_coord = h_q[14:0] - 15'd1 - row_q;
			res.red     = pix_word[23:16];
			res.green   = pix_word[15:8];
			res.blue    = pix_word[7:0];
			res.alpha   = four_q ? data_byte : bmpdec_pkg::ALPHA_OPAQUE;
		end else begin
			res.x_coord = 16'd0;
			res.y_coord = 15'd0;
			res.red     = 8'd0;
			res.green   = 8'd0;
			res.blue    = 8'd0;
			res.alpha   = 8'd0;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bmpdec_obuf.sv =====
`default_nettype none
module bmpdec_obuf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire bmpdec_pkg::res_t  res,
	input  wire logic              out_stall,
	output logic                   full,
	output logic                   out_valid,
	output bmpdec_pkg::res_t       out_res
);

	logic             out_valid_q;
	logic             skid_valid_q;
	bmpdec_pkg::res_t out_q;
	logic             take;
	bmpdec_pkg::res_t skid_q;

	assign take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule
`default_nettype wire

// ===== rtl/bmp_to_rgba_stream_decoder_core.sv =====
// BMP stream decoder: 24-bit and 32-bit BMP files in, RGBA pixels out.
// Write the file length through the cfg channel (cfg_ready is always high) before
// the first byte of a file. Bytes then arrive one per transfer on in_valid/in_stall,
// with end_of_file set on the final byte, after which the next file may follow.
// Each accepted byte gives at most one result: a pixel, or a status for an empty
// image, a too-short file, a bad mark, an unsupported header or a truncated file.
// A result is presented on out_valid from the output register, never combinationally.
// The block takes one byte per cycle while in_stall is low; the header size check is a two-stage
// multiply and add pipeline that settles between the height bytes and the depth byte.
// Results sit in an output register backed by one skid entry; when the receiver
// stalls, input keeps flowing until the skid entry fills, then in_stall rises until
// a transfer on the output side frees it.
// Reset clears the file length, all header fields and the parse position; the block
// then waits for the first byte of a file.
`default_nettype none
module bmp_to_rgba_stream_decoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_file,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic             last_result,
	output logic [15:0]      x_coord,
	output logic [14:0]      y_coord,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [7:0]       alpha,
	output logic [15:0]      image_width,
	output logic [14:0]      image_height
);

	logic              acc;
	logic              full;
	bmpdec_pkg::cmd_t  cmd;
	bmpdec_pkg::stat_t stat;
	bmpdec_pkg::res_t  res;
	bmpdec_pkg::res_t  out_res;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign acc       = in_valid && !full;

	bmpdec_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.eof    (end_of_file),
		.stat   (stat),
		.cmd    (cmd)
	);

	bmpdec_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.data_byte (data_byte),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res)
	);

	bmpdec_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd.emit),
		.res       (res),
		.out_stall (out_stall),
		.full      (full),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign status       = out_res.status;
	assign last_result  = out_res.last;
	assign x_coord      = out_res.x_coord;
	assign y_coord      = out_res.y_coord;
	assign red          = out_res.red;
	assign green        = out_res.green;
	assign blue         = out_res.blue;
	assign alpha        = out_res.alpha;
	assign image_width  = out_res.image_width;
	assign image_height = out_res.image_height;

	// The skid entry only fills behind a held output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("skid entry holds a result while the output register is empty");

	// Anything other than a pixel ends the file's results.
	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != bmpdec_pkg::ST_PIXEL) |-> last_result)
		else $error("non-pixel result without last_result");

	// A result appears only after a byte transfer.
	a_result_from_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall))
		else $error("result presented without an accepted byte");

	// Input back-pressure starts only while the receiver holds a result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("in_stall rose without an output stall");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none
module tb_top;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int FILL_RANDOM   = 0;
	localparam int FILL_ZERO     = 1;
	localparam int FILL_ONES     = 2;

	typedef enum int {PH_HEADER, PH_GAP, PH_PIXELS, PH_PAD, PH_DRAIN} parse_phase_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        end_of_file;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic        last_result;
	logic [15:0] x_coord;
	logic [14:0] y_coord;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [15:0] image_width;
	logic [14:0] image_height;

	// Decoder state as the testbench tracks it.
	logic [31:0]  length_reg = '0;
	int unsigned  cur_pos = 0;
	parse_phase_t cur_phase = PH_HEADER;
	logic [15:0]  hdr_offset = '0;
	logic [15:0]  hdr_width = '0;
	logic [15:0]  hdr_height = '0;
	bit           hdr_four = 1'b0;
	int unsigned  pix_col = 0;
	int unsigned  pix_row = 0;
	logic [1:0]   pix_chan = '0;
	logic [1:0]   pad_left = '0;
	logic [23:0]  pix_bytes = '0;

	bmpdec_pkg::res_t pending_results[$];
	logic [7:0]  bmp_bytes[$];
	logic [31:0] length_now = '0;
	bit          idle_bursts = 1'b0;
	int          errors = 0;
	int          results_seen = 0;
	int          bytes_in = 0;
	int          files_sent = 0;
	int          cfg_writes = 0;
	int          quiet_cycles = 0;

	bmp_to_rgba_stream_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.end_of_file(end_of_file),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.last_result(last_result),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.image_width(image_width),
		.image_height(image_height)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		errors++;
		if (errors <= 50)
			$display("mismatch at result %0d, %s: got %0d, expected %0d",
				results_seen, what, got, want);
	endtask

	// Works out what one accepted byte produces and queues it.
	task automatic decode_byte(input logic [7:0] d, input logic eof);
		bmpdec_pkg::res_t    r;
		bit                  emit;
		bit                  finished;
		bit                  has_err;
		bmpdec_pkg::status_t err_code;
		parse_phase_t        start_phase;
		logic [63:0]         scan;
		logic [63:0]         need_bytes;
		bit                  last_pix;
		logic [1:0]          pad;
		emit = 1'b0;
		finished = 1'b0;
		has_err = 1'b0;
		err_code = bmpdec_pkg::ST_PIXEL;
		start_phase = cur_phase;
		r = '0;
		case (cur_phase)
			PH_HEADER: begin
				case (cur_pos)
					0: begin
						hdr_offset = '0;
						hdr_width = '0;
						hdr_height = '0;
						hdr_four = 1'b0;
						if (length_reg < 32'(bmpdec_pkg::MIN_LEN)) begin
							has_err = 1'b1;
							err_code = bmpdec_pkg::ST_TOO_SHORT;
						end else if (d != bmpdec_pkg::CHAR_B) begin
							has_err = 1'b1;
							err_code = bmpdec_pkg::ST_BAD_MARK;
						end
					end
					1: begin
						if (d != bmpdec_pkg::CHAR_M) begin
							has_err = 1'b1;
							err_code = bmpdec_pkg::ST_BAD_MARK;
						end
					end
					10: hdr_offset[7:0] = d;
					11: hdr_offset[15:8] = d;
					18: hdr_width[7:0] = d;
					19: hdr_width[15:8] = d;
					22: hdr_height[7:0] = d;
					23: hdr_height[15:8] = d;
					28: begin
						hdr_four = (d == bmpdec_pkg::DEPTH32);
						if ((d != bmpdec_pkg::DEPTH24 && d != bmpdec_pkg::DEPTH32) ||
								hdr_height[15] || hdr_offset < bmpdec_pkg::MIN_LEN) begin
							has_err = 1'b1;
							err_code = bmpdec_pkg::ST_UNSUP;
						end else begin
							// The size check must not wrap, so it is done in 64 bits.
							scan = (64'(hdr_width) * (hdr_four ? 64'd4 : 64'd3) + 64'd3)
								& ~64'd3;
							need_bytes = scan * 64'(hdr_height) + 64'(hdr_offset);
							if (need_bytes > 64'(length_reg)) begin
								has_err = 1'b1;
								err_code = bmpdec_pkg::ST_TRUNC;
							end else if (hdr_width == 0 || hdr_height == 0) begin
								has_err = 1'b1;
								err_code = bmpdec_pkg::ST_EMPTY;
							end
						end
					end
					53: begin
						cur_phase = (hdr_offset == bmpdec_pkg::MIN_LEN) ? PH_PIXELS : PH_GAP;
						pix_col = 0;
						pix_row = 0;
						pix_chan = '0;
						pix_bytes = '0;
					end
					default: ;
				endcase
				if (has_err) begin
					r.status = err_code;
					r.last = 1'b1;
					r.image_width = hdr_width;
					r.image_height = hdr_height[14:0];
					emit = 1'b1;
					finished = 1'b1;
					cur_phase = PH_DRAIN;
				end
				cur_pos++;
			end
			PH_GAP: begin
				if (cur_pos + 1 >= hdr_offset)
					cur_phase = PH_PIXELS;
				cur_pos++;
			end
			PH_PIXELS: begin
				if (pix_chan < 2'd3)
					pix_bytes[8*pix_chan +: 8] = d;
				if (pix_chan >= (hdr_four ? 2'd3 : 2'd2)) begin
					last_pix = (pix_col + 1 >= hdr_width) && (pix_row + 1 >= hdr_height);
					r.status = bmpdec_pkg::ST_PIXEL;
					r.last = last_pix;
					r.x_coord = 16'(pix_col);
					r.y_coord = 15'(32'(hdr_height) - 32'd1 - pix_row);
					r.red = pix_bytes[23:16];
					r.green = pix_bytes[15:8];
					r.blue = pix_bytes[7:0];
					r.alpha = hdr_four ? d : bmpdec_pkg::ALPHA_OPAQUE;
					r.image_width = hdr_width;
					r.image_height = hdr_height[14:0];
					emit = 1'b1;
					pix_col++;
					pix_chan = '0;
					pix_bytes = '0;
					if (last_pix) begin
						finished = 1'b1;
						cur_phase = PH_DRAIN;
					end else if (pix_col >= hdr_width) begin
						pad = hdr_four ? 2'd0 : hdr_width[1:0];
						pix_col = 0;
						pix_row++;
						if (pad != 0) begin
							pad_left = pad;
							cur_phase = PH_PAD;
						end
					end
				end else begin
					pix_chan++;
				end
			end
			PH_PAD: begin
				if (pad_left > 0)
					pad_left--;
				if (pad_left == 0)
					cur_phase = PH_PIXELS;
			end
			default: ;
		endcase
		if (eof) begin
			// An unfinished file ends in a truncation status, which also replaces
			// a pixel completed by this byte.
			if (!finished && start_phase != PH_DRAIN) begin
				r = '0;
				r.status = bmpdec_pkg::ST_TRUNC;
				r.last = 1'b1;
				r.image_width = hdr_width;
				r.image_height = hdr_height[14:0];
				emit = 1'b1;
			end
			cur_pos = 0;
			cur_phase = PH_HEADER;
			pix_col = 0;
			pix_row = 0;
			pix_chan = '0;
			pad_left = '0;
			pix_bytes = '0;
		end
		if (emit)
			pending_results = {pending_results, r};
	endtask

	task automatic check_result();
		bmpdec_pkg::res_t want;
		results_seen++;
		if (pending_results.size() == 0) begin
			report_mismatch("result with nothing pending, status", status, 0);
			return;
		end
		want = pending_results.pop_front();
		if (status !== want.status)
			report_mismatch("status", status, want.status);
		if (last_result !== want.last)
			report_mismatch("last_result", last_result, want.last);
		if (x_coord !== want.x_coord)
			report_mismatch("x_coord", x_coord, want.x_coord);
		if (y_coord !== want.y_coord)
			report_mismatch("y_coord", y_coord, want.y_coord);
		if (red !== want.red)
			report_mismatch("red", red, want.red);
		if (green !== want.green)
			report_mismatch("green", green, want.green);
		if (blue !== want.blue)
			report_mismatch("blue", blue, want.blue);
		if (alpha !== want.alpha)
			report_mismatch("alpha", alpha, want.alpha);
		if (image_width !== want.image_width)
			report_mismatch("image_width", image_width, want.image_width);
		if (image_height !== want.image_height)
			report_mismatch("image_height", image_height, want.image_height);
	endtask

	// Output checks come before input prediction, so a result is always matched
	// against expectations from earlier transfers.
	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (arst_n && out_valid && !out_stall) begin
			check_result();
			moved = 1'b1;
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			length_reg = cfg_data;
			cfg_writes++;
			moved = 1'b1;
		end
		if (arst_n && in_valid && !in_stall) begin
			decode_byte(data_byte, end_of_file);
			bytes_in++;
			moved = 1'b1;
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no transfer for %0d cycles, %0d results still pending",
				quiet_cycles, pending_results.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver back-pressure in random bursts.
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && idle_bursts && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 12);
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eof);
		@(negedge clk);
		if (idle_bursts && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_file <= eof;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input logic [31:0] v);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		length_now = v;
	endtask

	// Builds a file image; header bytes with no meaning to the decoder are random.
	task automatic build_bmp(input logic [15:0] off, input logic [15:0] wid,
			input logic [15:0] hgt, input logic [7:0] depth, input bit with_pixels,
			input int trailing, input int fill_mode);
		int unsigned ch;
		int unsigned pad;
		int i;
		int row_i;
		int col_i;
		bmp_bytes.delete();
		for (i = 0; i < 54; i++)
			bmp_bytes = {bmp_bytes, 8'($urandom)};
		bmp_bytes[0] = bmpdec_pkg::CHAR_B;
		bmp_bytes[1] = bmpdec_pkg::CHAR_M;
		bmp_bytes[10] = off[7:0];
		bmp_bytes[11] = off[15:8];
		bmp_bytes[18] = wid[7:0];
		bmp_bytes[19] = wid[15:8];
		bmp_bytes[22] = hgt[7:0];
		bmp_bytes[23] = hgt[15:8];
		bmp_bytes[28] = depth;
		if (with_pixels) begin
			ch = (depth == bmpdec_pkg::DEPTH32) ? 4 : 3;
			pad = (4 - (wid * ch) % 4) % 4;
			for (i = 54; i < off; i++)
				bmp_bytes = {bmp_bytes, 8'($urandom)};
			for (row_i = 0; row_i < hgt; row_i++)
				for (col_i = 0; col_i < wid * ch + pad; col_i++)
					bmp_bytes = {bmp_bytes, (fill_mode == FILL_ZERO) ? 8'h00 :
						(fill_mode == FILL_ONES) ? 8'hFF : 8'($urandom)};
		end
		repeat (trailing) bmp_bytes = {bmp_bytes, 8'($urandom)};
	endtask

	task automatic send_file();
		int i;
		for (i = 0; i < bmp_bytes.size(); i++)
			send_byte(bmp_bytes[i], i == bmp_bytes.size() - 1);
		files_sent++;
	endtask

	task automatic run_file(input logic [31:0] len);
		if (len !== length_now)
			write_length(len);
		send_file();
	endtask

	task automatic test_header_checks();
		build_bmp(54, 1, 1, bmpdec_pkg::DEPTH24, 1, 0, FILL_RANDOM);
		write_length(32'd0);
		send_file();
		run_file(32'd53);
		build_bmp(54, 2, 2, bmpdec_pkg::DEPTH24, 1, 0, FILL_RANDOM);
		bmp_bytes[0] = 8'h00;
		run_file(bmp_bytes.size());
		build_bmp(54, 2, 2, bmpdec_pkg::DEPTH24, 1, 0, FILL_RANDOM);
		bmp_bytes[1] = bmpdec_pkg::CHAR_B;
		run_file(bmp_bytes.size());
		build_bmp(54, 2, 2, 8'd16, 0, 10, FILL_RANDOM);
		run_file(bmp_bytes.size());
		build_bmp(54, 2, 16'hFFFE, bmpdec_pkg::DEPTH24, 0, 4, FILL_RANDOM);
		run_file(bmp_bytes.size());
		build_bmp(53, 2, 2, bmpdec_pkg::DEPTH32, 0, 4, FILL_RANDOM);
		run_file(bmp_bytes.size());
		build_bmp(54, 3, 2, bmpdec_pkg::DEPTH24, 1, 0, FILL_RANDOM);
		run_file(bmp_bytes.size() - 1);
		build_bmp(54, 0, 3, bmpdec_pkg::DEPTH32, 0, 5, FILL_RANDOM);
		run_file(bmp_bytes.size());
		build_bmp(54, 16'hFFFF, 0, bmpdec_pkg::DEPTH24, 0, 0, FILL_RANDOM);
		run_file(32'hFFFF_FFFF);
		// This size only fits the length register if the product wraps.
		build_bmp(54, 16'hFFFF, 16'h7FFF, bmpdec_pkg::DEPTH32, 0, 0, FILL_RANDOM);
		run_file(32'hFFFF_FFFF);
	endtask

	task automatic test_pixel_layouts();
		int w;
		for (w = 1; w <= 4; w++) begin
			build_bmp(54, 16'(w), 2, bmpdec_pkg::DEPTH24, 1, 0, FILL_RANDOM);
			run_file(bmp_bytes.size());
		end
		build_bmp(54, 1, 1, bmpdec_pkg::DEPTH24, 1, 0, FILL_ZERO);
		run_file(bmp_bytes.size());
		build_bmp(54, 2, 1, bmpdec_pkg::DEPTH32, 1, 0, FILL_ONES);
		run_file(bmp_bytes.size());
		build_bmp(58, 3, 2, bmpdec_pkg::DEPTH32, 1, 3, FILL_RANDOM);
		run_file(bmp_bytes.size());
		build_bmp(55, 3, 3, bmpdec_pkg::DEPTH24, 1, 2, FILL_RANDOM);
		run_file(bmp_bytes.size());
	endtask

	task automatic test_early_end();
		logic [31:0] len;
		build_bmp(54, 2, 2, bmpdec_pkg::DEPTH24, 1, 0, FILL_RANDOM);
		len = bmp_bytes.size();
		bmp_bytes = bmp_bytes[0:19];
		run_file(len);
		build_bmp(54, 2, 2, bmpdec_pkg::DEPTH24, 1, 0, FILL_RANDOM);
		bmp_bytes = bmp_bytes[0:0];
		run_file(len);
		build_bmp(54, 2, 2, bmpdec_pkg::DEPTH24, 1, 0, FILL_RANDOM);
		bmp_bytes[1] = 8'h00;
		bmp_bytes = bmp_bytes[0:1];
		run_file(len);
		build_bmp(54, 2, 2, bmpdec_pkg::DEPTH24, 1, 0, FILL_RANDOM);
		bmp_bytes = bmp_bytes[0:53];
		run_file(len);
		build_bmp(54, 2, 2, bmpdec_pkg::DEPTH24, 1, 0, FILL_RANDOM);
		bmp_bytes = bmp_bytes[0:54];
		run_file(len);
		// The final byte completes a pixel, but the file ends there.
		build_bmp(54, 2, 2, bmpdec_pkg::DEPTH24, 1, 0, FILL_RANDOM);
		bmp_bytes = bmp_bytes[0:56];
		run_file(len);
		build_bmp(60, 2, 2, bmpdec_pkg::DEPTH24, 1, 0, FILL_RANDOM);
		len = bmp_bytes.size();
		bmp_bytes = bmp_bytes[0:56];
		run_file(len);
		build_bmp(54, 1, 2, bmpdec_pkg::DEPTH24, 1, 0, FILL_RANDOM);
		len = bmp_bytes.size();
		bmp_bytes = bmp_bytes[0:57];
		run_file(len);
	endtask

	// Mostly well-formed files with random content; the rest are cut short,
	// damaged or plain noise. Reused shapes go back to back with no register write.
	task automatic test_random_files();
		int          start_bytes;
		int          files;
		int          kind;
		int          n;
		logic [15:0] off;
		logic [15:0] wid;
		logic [15:0] hgt;
		logic [7:0]  dep;
		int          trailing;
		logic [31:0] len;
		start_bytes = bytes_in;
		files = 0;
		off = 16'd54;
		wid = 16'd2;
		hgt = 16'd2;
		dep = bmpdec_pkg::DEPTH24;
		trailing = 0;
		while (files < 16 || bytes_in - start_bytes < 400) begin
			kind = $urandom_range(0, 9);
			if (files == 0 || $urandom_range(0, 1) == 0) begin
				dep = ($urandom_range(0, 1) == 0) ? bmpdec_pkg::DEPTH32 : bmpdec_pkg::DEPTH24;
				if ($urandom_range(0, 9) == 0) begin
					wid = 16'($urandom_range(40, 120));
					hgt = 16'd1;
				end else begin
					wid = 16'($urandom_range(1, 6));
					hgt = 16'($urandom_range(1, 4));
				end
				off = ($urandom_range(0, 2) == 0) ? 16'(54 + $urandom_range(1, 4)) : 16'd54;
				trailing = $urandom_range(0, 2);
			end
			build_bmp(off, wid, hgt, dep, 1, trailing, FILL_RANDOM);
			len = bmp_bytes.size();
			case (kind)
				7: begin
					n = $urandom_range(1, bmp_bytes.size() - 1);
					bmp_bytes = bmp_bytes[0:n-1];
				end
				8: begin
					case ($urandom_range(0, 4))
						0: bmp_bytes[$urandom_range(0, 1)] = 8'($urandom);
						1: bmp_bytes[28] = 8'($urandom);
						2: bmp_bytes[23] = bmp_bytes[23] | 8'h80;
						3: len = $urandom_range(0, bmp_bytes.size() - 1);
						default: begin
							bmp_bytes[10] = 8'($urandom_range(0, 53));
							bmp_bytes[11] = 8'h00;
						end
					endcase
				end
				9: begin
					n = $urandom_range(1, 80);
					bmp_bytes.delete();
					repeat (n) bmp_bytes = {bmp_bytes, 8'($urandom)};
					if (n >= 2 && $urandom_range(0, 1) == 0) begin
						bmp_bytes[0] = bmpdec_pkg::CHAR_B;
						bmp_bytes[1] = bmpdec_pkg::CHAR_M;
					end
					len = $urandom;
				end
				default: ;
			endcase
			run_file(len);
			files++;
		end
	endtask

	// Full-rate traffic with no stalls; files of one shape follow each other directly.
	task automatic test_steady_stream();
		idle_bursts = 1'b0;
		build_bmp(55, 3, 2, bmpdec_pkg::DEPTH24, 1, 1, FILL_RANDOM);
		run_file(bmp_bytes.size());
		repeat (3) send_file();
		build_bmp(54, 2, 3, bmpdec_pkg::DEPTH32, 1, 0, FILL_RANDOM);
		run_file(bmp_bytes.size());
		repeat (2) send_file();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		data_byte = '0;
		end_of_file = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		idle_bursts = 1'b1;
		test_header_checks();
		test_pixel_layouts();
		test_early_end();
		test_random_files();
		test_steady_stream();
		settle();
		$display("Streamed %0d files (%0d bytes) with %0d length writes.",
			files_sent, bytes_in, cfg_writes);
		$display("Checked %0d results with %0d mismatches.", results_seen, errors);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
